FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/i64ht_pkg.sv
// Package for the ICMPv6 to ICMPv4 header translator.
// Holds message codes, verdicts, stage word types and the pointer remap function.
package i64ht_pkg;

  // Configuration port geometry.
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;
  localparam logic [ApbAddrW-1:0] RegNat64Mode = 3'd0;

  // ICMPv6 message types.
  localparam logic [7:0] Icmp6DestUnreach = 8'd1;
  localparam logic [7:0] Icmp6PktTooBig   = 8'd2;
  localparam logic [7:0] Icmp6TimeExceed  = 8'd3;
  localparam logic [7:0] Icmp6ParamProb   = 8'd4;
  localparam logic [7:0] Icmp6EchoReq     = 8'd128;
  localparam logic [7:0] Icmp6EchoReply   = 8'd129;

  // ICMPv4 message types.
  localparam logic [7:0] Icmp4EchoReply   = 8'd0;
  localparam logic [7:0] Icmp4DestUnreach = 8'd3;
  localparam logic [7:0] Icmp4Echo        = 8'd8;
  localparam logic [7:0] Icmp4TimeExceed  = 8'd11;
  localparam logic [7:0] Icmp4ParamProb   = 8'd12;

  // ICMPv4 destination unreachable codes.
  localparam logic [7:0] Icmp4CodeZero       = 8'd0;
  localparam logic [7:0] Icmp4CodeHostUnr    = 8'd1;
  localparam logic [7:0] Icmp4CodeProtoUnr   = 8'd2;
  localparam logic [7:0] Icmp4CodePortUnr    = 8'd3;
  localparam logic [7:0] Icmp4CodeFragNeeded = 8'd4;
  localparam logic [7:0] Icmp4CodeHostProhib = 8'd10;

  // ICMPv6 codes that are translated.
  localparam logic [7:0] Icmp6CodeNoRoute   = 8'd0;
  localparam logic [7:0] Icmp6CodeAdminProh = 8'd1;
  localparam logic [7:0] Icmp6CodeBeyondScp = 8'd2;
  localparam logic [7:0] Icmp6CodeAddrUnr   = 8'd3;
  localparam logic [7:0] Icmp6CodePortUnr   = 8'd4;
  localparam logic [7:0] Icmp6CodeErrHeader = 8'd0;
  localparam logic [7:0] Icmp6CodeNextHdr   = 8'd1;

  // IPv6 and IPv4 header length difference, and pointer remap bounds.
  localparam int HdrDelta   = 20;
  localparam int PtrMax     = 39;
  localparam int PtrSrcBase = 24;
  localparam int PtrDstBase = 8;
  localparam logic [4:0] Ptr4Dst = 5'd16;
  localparam logic [4:0] Ptr4Src = 5'd12;
  localparam logic [4:0] Ptr4Proto = 5'd9;
  localparam logic [4:0] Ptr4Ttl = 5'd8;
  localparam logic [4:0] Ptr4Len = 5'd2;

  typedef enum logic [1:0] {
    VERDICT_INFO    = 2'd0,
    VERDICT_ERROR   = 2'd1,
    VERDICT_DISCARD = 2'd2
  } verdict_t;

  // Result of a parameter problem pointer remap.
  typedef struct packed {
    logic       ok;
    logic [4:0] p4;
  } ptr_map_t;

  // Word carried between pipeline stages.
  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  icmp4_type;
    logic [7:0]  icmp4_code;
    logic        is_mtu;
    logic [31:0] rest_fixed;
    logic [15:0] mtu_a;
    logic [15:0] mtu_b;
    logic [15:0] mtu_c;
  } stage_word_t;

  // Maps an IPv6 header pointer to its IPv4 header counterpart.
  function automatic ptr_map_t map_pointer(input logic [31:0] p6);
    ptr_map_t r;
    r.ok = 1'b1;
    r.p4 = '0;
    if (p6 > 32'(PtrMax)) begin
      r.ok = 1'b0;
    end else if (p6 >= 32'(PtrSrcBase)) begin
      r.p4 = Ptr4Dst;
    end else if (p6 >= 32'(PtrDstBase)) begin
      r.p4 = Ptr4Src;
    end else begin
      unique case (p6[2:0])
        3'd0: r.p4 = 5'd0;
        3'd1: r.p4 = 5'd1;
        3'd4, 3'd5: r.p4 = Ptr4Len;
        3'd6: r.p4 = Ptr4Proto;
        3'd7: r.p4 = Ptr4Ttl;
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/i64ht_decode.sv
// First pipeline stage: decodes the ICMPv6 header and prepares MTU operands.
// Depends on i64ht_pkg.
module i64ht_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  nat64_mode,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            v6_type,
  input  logic [7:0]            v6_code,
  input  logic [31:0]           rest_word,
  input  logic [15:0]           mapped_echo_id,
  input  logic [15:0]           in_dev_mtu,
  input  logic [15:0]           out_dev_mtu,
  input  logic                  route_found,
  output logic                  s1_valid,
  input  logic                  s1_ready,
  output i64ht_pkg::stage_word_t s1
);
  import i64ht_pkg::*;

  stage_word_t s1_next;
  ptr_map_t    ptr;
  logic [31:0] rest_sub;
  logic [15:0] in_mtu_sub;

  // The stage takes a word when it is empty or its word moves on.
  assign in_ready = !s1_valid || s1_ready;

  // Saturating header length corrections for the MTU path.
  assign rest_sub   = (rest_word >= 32'(HdrDelta)) ? rest_word - 32'(HdrDelta) : '0;
  assign in_mtu_sub = (in_dev_mtu >= 16'(HdrDelta)) ? in_dev_mtu - 16'(HdrDelta) : '0;
  assign ptr        = map_pointer(rest_word);

  // Type and code translation; anything not listed is dropped with zeros.
  always_comb begin
    s1_next            = '0;
    s1_next.verdict    = VERDICT_DISCARD;
    s1_next.mtu_a      = (|rest_sub[31:16]) ? 16'hFFFF : rest_sub[15:0];
    s1_next.mtu_b      = out_dev_mtu;
    s1_next.mtu_c      = in_mtu_sub;
    unique case (v6_type)
      Icmp6EchoReq, Icmp6EchoReply: begin
        s1_next.verdict    = VERDICT_INFO;
        s1_next.icmp4_type = (v6_type == Icmp6EchoReq) ? Icmp4Echo : Icmp4EchoReply;
        s1_next.icmp4_code = Icmp4CodeZero;
        s1_next.rest_fixed = {(nat64_mode ? mapped_echo_id : rest_word[31:16]),
                              rest_word[15:0]};
      end
      Icmp6DestUnreach: begin
        s1_next.icmp4_type = Icmp4DestUnreach;
        unique case (v6_code)
          Icmp6CodeNoRoute, Icmp6CodeBeyondScp, Icmp6CodeAddrUnr: begin
            s1_next.verdict    = VERDICT_ERROR;
            s1_next.icmp4_code = Icmp4CodeHostUnr;
          end
          Icmp6CodeAdminProh: begin
            s1_next.verdict    = VERDICT_ERROR;
            s1_next.icmp4_code = Icmp4CodeHostProhib;
          end
          Icmp6CodePortUnr: begin
            s1_next.verdict    = VERDICT_ERROR;
            s1_next.icmp4_code = Icmp4CodePortUnr;
          end
          default: s1_next.icmp4_type = '0;
        endcase
      end
      Icmp6PktTooBig: begin
        if (route_found) begin
          s1_next.verdict    = VERDICT_ERROR;
          s1_next.icmp4_type = Icmp4DestUnreach;
          s1_next.icmp4_code = Icmp4CodeFragNeeded;
          s1_next.is_mtu     = 1'b1;
        end
      end
      Icmp6TimeExceed: begin
        s1_next.verdict    = VERDICT_ERROR;
        s1_next.icmp4_type = Icmp4TimeExceed;
        s1_next.icmp4_code = v6_code;
      end
      Icmp6ParamProb: begin
        if (v6_code == Icmp6CodeErrHeader && ptr.ok) begin
          s1_next.verdict    = VERDICT_ERROR;
          s1_next.icmp4_type = Icmp4ParamProb;
          s1_next.icmp4_code = Icmp4CodeZero;
          s1_next.rest_fixed = {3'b000, ptr.p4, 24'h000000};
        end else if (v6_code == Icmp6CodeNextHdr) begin
          s1_next.verdict    = VERDICT_ERROR;
          s1_next.icmp4_type = Icmp4DestUnreach;
          s1_next.icmp4_code = Icmp4CodeProtoUnr;
        end
      end
      default: ;
    endcase
  end

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1 <= s1_next;
    end
  end

endmodule

FILE: hw/rtl/i64ht_mtu_min.sv
// Second pipeline stage: first compare of the packet too big MTU minimum.
// Depends on i64ht_pkg.
module i64ht_mtu_min (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s1_valid,
  output logic                   s1_ready,
  input  i64ht_pkg::stage_word_t s1,
  output logic                   s2_valid,
  input  logic                   s2_ready,
  output i64ht_pkg::stage_word_t s2
);
  import i64ht_pkg::*;

  stage_word_t s2_next;

  assign s1_ready = !s2_valid || s2_ready;

  // Smaller of the corrected packet MTU and the outgoing device MTU.
  always_comb begin
    s2_next       = s1;
    s2_next.mtu_a = (s1.mtu_b < s1.mtu_a) ? s1.mtu_b : s1.mtu_a;
  end

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
    if (s1_valid && s1_ready) begin
      s2 <= s2_next;
    end
  end

endmodule

FILE: hw/rtl/icmp6_to_icmp4_header_translator.sv
// ICMPv6 to ICMPv4 header translator, top level with configuration port and output stage.
// Depends on i64ht_pkg, i64ht_decode and i64ht_mtu_min.
//
// Takes one ICMPv6 header word per cycle and returns one ICMPv4 header word with a
// verdict once it has passed the three register stages (decode, MTU compare, output
// register); each holds one word, so a new word enters every cycle
// while out_ready is high. When the output stalls, words stay in their stages and
// in_ready falls once all three are full. The nat64_mode register sits at byte address 0
// and is to be written only while no word is in flight.
module icmp6_to_icmp4_header_translator (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [i64ht_pkg::ApbAddrW-1:0] paddr,
  input  logic [i64ht_pkg::ApbDataW-1:0] pwdata,
  output logic [i64ht_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     v6_type,
  input  logic [7:0]                     v6_code,
  input  logic [31:0]                    rest_word,
  input  logic [15:0]                    mapped_echo_id,
  input  logic [15:0]                    in_dev_mtu,
  input  logic [15:0]                    out_dev_mtu,
  input  logic                           route_found,
  // Output channel.
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     icmp4_type,
  output logic [7:0]                     icmp4_code,
  output logic [31:0]                    icmp4_rest,
  output logic [1:0]                     verdict
);
  import i64ht_pkg::*;

  logic        nat64_mode;
  logic        s1_valid;
  logic        s1_ready;
  logic        s2_valid;
  logic        s2_ready;
  stage_word_t s1;
  stage_word_t s2;
  logic [15:0] mtu_min;
  logic [31:0] rest_next;
  logic [7:0]  out_type;
  logic [7:0]  out_code;
  logic [31:0] out_rest;
  verdict_t    out_verdict;

  // Configuration register write and read back.
  assign pready = 1'b1;
  assign prdata = (paddr == RegNat64Mode) ? {{(ApbDataW-1){1'b0}}, nat64_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      nat64_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == RegNat64Mode) begin
      nat64_mode <= pwdata[0];
    end
  end

  // Decode stage.
  i64ht_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .nat64_mode     (nat64_mode),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .v6_type        (v6_type),
    .v6_code        (v6_code),
    .rest_word      (rest_word),
    .mapped_echo_id (mapped_echo_id),
    .in_dev_mtu     (in_dev_mtu),
    .out_dev_mtu    (out_dev_mtu),
    .route_found    (route_found),
    .s1_valid       (s1_valid),
    .s1_ready       (s1_ready),
    .s1             (s1)
  );

  // MTU compare stage.
  i64ht_mtu_min u_mtu_min (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  // Final compare against the corrected input device MTU and rest word selection.
  assign mtu_min   = (s2.mtu_c < s2.mtu_a) ? s2.mtu_c : s2.mtu_a;
  assign rest_next = s2.is_mtu ? {16'h0000, mtu_min} : s2.rest_fixed;
  assign s2_ready  = !out_valid || out_ready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
    if (s2_valid && s2_ready) begin
      out_type    <= s2.icmp4_type;
      out_code    <= s2.icmp4_code;
      out_rest    <= rest_next;
      out_verdict <= s2.verdict;
    end
  end

  assign icmp4_type = out_type;
  assign icmp4_code = out_code;
  assign icmp4_rest = out_rest;
  assign verdict    = out_verdict;

endmodule

FILE: hw/rtl/i64ht_checker.sv
// Port-level checker for the ICMPv6 to ICMPv4 header translator, bound to the top level.
// Depends on i64ht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i64ht_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  icmp4_type,
  input logic [7:0]  icmp4_code,
  input logic [31:0] icmp4_rest,
  input logic [1:0]  verdict
);
  import i64ht_pkg::*;

  // A word shown but not taken stays in place.
  `CHK_ASSERT(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(icmp4_type) && $stable(icmp4_code) &&
      $stable(icmp4_rest) && $stable(verdict),
    "output word changed while stalled")

  // An empty output register means the pipeline can take a word.
  `CHK_ASSERT(a_ready_when_empty, clk, rst, !out_valid |-> in_ready,
    "input stalled with an empty output stage")

  // A dropped message carries an all-zero header.
  `CHK_ASSERT(a_drop_zero, clk, rst,
    out_valid && verdict == VERDICT_DISCARD |->
      icmp4_type == '0 && icmp4_code == '0 && icmp4_rest == '0,
    "dropped word has a nonzero header")

  // Informational results are echo messages with code zero.
  `CHK_ASSERT(a_info_echo, clk, rst,
    out_valid && verdict == VERDICT_INFO |->
      (icmp4_type == Icmp4Echo || icmp4_type == Icmp4EchoReply) &&
      icmp4_code == Icmp4CodeZero,
    "informational word is not an echo")

  // Reset empties the output stage.
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind icmp6_to_icmp4_header_translator i64ht_checker u_i64ht_checker (.*);

FILE: dv/tb_top.sv
// Self-checking testbench for the ICMPv6 to ICMPv4 header translator.
// Drives header words and APB writes, predicts every output word and checks it.
// Depends on i64ht_pkg and the icmp6_to_icmp4_header_translator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i64ht_pkg::*;

  localparam int PipeDepth  = 3;
  localparam int HoldCycles = 120;
  localparam int MaxReports = 10;

  typedef struct {
    logic [7:0]  msg_type;
    logic [7:0]  code;
    logic [31:0] rest;
    logic [15:0] mid;
    logic [15:0] in_mtu;
    logic [15:0] out_mtu;
    logic        route;
  } icmp6_hdr_t;

  typedef struct {
    logic [7:0]  msg_type;
    logic [7:0]  code;
    logic [31:0] rest;
    verdict_t    verdict;
  } icmp4_hdr_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic [7:0] v6_type;
  logic [7:0] v6_code;
  logic [31:0] rest_word;
  logic [15:0] mapped_echo_id;
  logic [15:0] in_dev_mtu;
  logic [15:0] out_dev_mtu;
  logic route_found;
  logic out_valid;
  logic out_ready;
  logic [7:0] icmp4_type;
  logic [7:0] icmp4_code;
  logic [31:0] icmp4_rest;
  logic [1:0] verdict;

  // Shadow of the configuration and the words still owed by the block.
  logic nat64_cfg = 1'b0;
  icmp4_hdr_t pending_icmp4_q[$];
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit hold_req = 1'b0;

  icmp6_to_icmp4_header_translator i_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .v6_type        (v6_type),
    .v6_code        (v6_code),
    .rest_word      (rest_word),
    .mapped_echo_id (mapped_echo_id),
    .in_dev_mtu     (in_dev_mtu),
    .out_dev_mtu    (out_dev_mtu),
    .route_found    (route_found),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .icmp4_type     (icmp4_type),
    .icmp4_code     (icmp4_code),
    .icmp4_rest     (icmp4_rest),
    .verdict        (verdict)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Subtract the header length difference, clamping at zero.
  function automatic logic [31:0] minus_hdr_delta(input logic [31:0] v);
    return (v >= 32'(HdrDelta)) ? v - 32'(HdrDelta) : 32'd0;
  endfunction

  // Map an IPv6 header offset to the matching IPv4 header offset.
  function automatic bit remap_ptr(input logic [31:0] p6, output logic [4:0] p4);
    p4 = '0;
    if (p6 > 32'(PtrMax)) return 1'b0;
    if (p6 >= 32'(PtrSrcBase)) begin
      p4 = Ptr4Dst;
      return 1'b1;
    end
    if (p6 >= 32'(PtrDstBase)) begin
      p4 = Ptr4Src;
      return 1'b1;
    end
    case (p6[2:0])
      3'd0: p4 = 5'd0;
      3'd1: p4 = 5'd1;
      3'd4, 3'd5: p4 = Ptr4Len;
      3'd6: p4 = Ptr4Proto;
      3'd7: p4 = Ptr4Ttl;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Expected ICMPv4 header for one ICMPv6 header under the given mode.
  function automatic icmp4_hdr_t predict_icmp4(input icmp6_hdr_t h, input logic nat64);
    icmp4_hdr_t r;
    logic [4:0] p4;
    logic [31:0] mtu;
    r.msg_type = '0;
    r.code = '0;
    r.rest = '0;
    r.verdict = VERDICT_DISCARD;
    case (h.msg_type)
      Icmp6EchoReq, Icmp6EchoReply: begin
        r.msg_type = (h.msg_type == Icmp6EchoReq) ? Icmp4Echo : Icmp4EchoReply;
        r.code = Icmp4CodeZero;
        r.rest = {nat64 ? h.mid : h.rest[31:16], h.rest[15:0]};
        r.verdict = VERDICT_INFO;
      end
      Icmp6DestUnreach: begin
        r.msg_type = Icmp4DestUnreach;
        r.verdict = VERDICT_ERROR;
        case (h.code)
          Icmp6CodeNoRoute, Icmp6CodeBeyondScp, Icmp6CodeAddrUnr: r.code = Icmp4CodeHostUnr;
          Icmp6CodeAdminProh: r.code = Icmp4CodeHostProhib;
          Icmp6CodePortUnr: r.code = Icmp4CodePortUnr;
          default: r.verdict = VERDICT_DISCARD;
        endcase
      end
      Icmp6PktTooBig: begin
        if (h.route) begin
          // The MTU is the smallest of the three candidates.
          mtu = minus_hdr_delta(h.rest);
          if ({16'd0, h.out_mtu} < mtu) mtu = {16'd0, h.out_mtu};
          if (minus_hdr_delta({16'd0, h.in_mtu}) < mtu) mtu = minus_hdr_delta({16'd0, h.in_mtu});
          r.msg_type = Icmp4DestUnreach;
          r.code = Icmp4CodeFragNeeded;
          r.rest = {16'd0, mtu[15:0]};
          r.verdict = VERDICT_ERROR;
        end
      end
      Icmp6TimeExceed: begin
        r.msg_type = Icmp4TimeExceed;
        r.code = h.code;
        r.verdict = VERDICT_ERROR;
      end
      Icmp6ParamProb: begin
        if (h.code == Icmp6CodeErrHeader) begin
          if (remap_ptr(h.rest, p4)) begin
            r.msg_type = Icmp4ParamProb;
            r.code = Icmp4CodeZero;
            r.rest = {3'd0, p4, 24'd0};
            r.verdict = VERDICT_ERROR;
          end
        end else if (h.code == Icmp6CodeNextHdr) begin
          r.msg_type = Icmp4DestUnreach;
          r.code = Icmp4CodeProtoUnr;
          r.verdict = VERDICT_ERROR;
        end
      end
      default: ;
    endcase
    if (r.verdict == VERDICT_DISCARD) begin
      r.msg_type = '0;
      r.code = '0;
      r.rest = '0;
    end
    return r;
  endfunction

  function automatic icmp6_hdr_t mk_hdr(input logic [7:0] t, input logic [7:0] c,
                                        input logic [31:0] rest, input logic [15:0] mid,
                                        input logic [15:0] in_mtu, input logic [15:0] out_mtu,
                                        input logic route);
    icmp6_hdr_t h;
    h.msg_type = t;
    h.code = c;
    h.rest = rest;
    h.mid = mid;
    h.in_mtu = in_mtu;
    h.out_mtu = out_mtu;
    h.route = route;
    return h;
  endfunction

  // Random header: mostly translatable messages with random content, some noise.
  function automatic icmp6_hdr_t rand_hdr();
    icmp6_hdr_t h;
    int unsigned pick;
    h = mk_hdr(8'($urandom), 8'($urandom), $urandom, 16'($urandom), 16'($urandom),
               16'($urandom), 1'($urandom));
    if ($urandom_range(0, 99) < 15) return h;
    pick = $urandom_range(0, 5);
    case (pick)
      0: h.msg_type = Icmp6EchoReq;
      1: h.msg_type = Icmp6EchoReply;
      2: begin
        h.msg_type = Icmp6DestUnreach;
        if ($urandom_range(0, 3) != 0) h.code = 8'($urandom_range(0, 5));
      end
      3: begin
        h.msg_type = Icmp6PktTooBig;
        h.route = ($urandom_range(0, 4) != 0);
        pick = $urandom_range(0, 3);
        if (pick == 0) h.rest = $urandom_range(0, 40);
        else if (pick != 3) h.rest = $urandom_range(1200, 1600);
        pick = $urandom_range(0, 3);
        if (pick == 0) h.in_mtu = 16'($urandom_range(0, 40));
        else if (pick != 3) h.in_mtu = 16'($urandom_range(1200, 1600));
        pick = $urandom_range(0, 3);
        if (pick == 0) h.out_mtu = 16'($urandom_range(0, 40));
        else if (pick != 3) h.out_mtu = 16'($urandom_range(1200, 1600));
      end
      4: h.msg_type = Icmp6TimeExceed;
      default: begin
        h.msg_type = Icmp6ParamProb;
        pick = $urandom_range(0, 99);
        if (pick < 60) h.code = Icmp6CodeErrHeader;
        else if (pick < 85) h.code = Icmp6CodeNextHdr;
        if ($urandom_range(0, 9) < 7) h.rest = $urandom_range(0, 45);
      end
    endcase
    return h;
  endfunction

  // Offer one word, with an optional random gap first, and wait for acceptance.
  task automatic send_hdr(input icmp6_hdr_t h);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    v6_type <= h.msg_type;
    v6_code <= h.code;
    rest_word <= h.rest;
    mapped_echo_id <= h.mid;
    in_dev_mtu <= h.in_mtu;
    out_dev_mtu <= h.out_mtu;
    route_found <= h.route;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_icmp4_q.push_back(predict_icmp4(h, nat64_cfg));
  endtask

  // Stop offering and let the pipeline empty out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_icmp4_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [ApbAddrW-1:0] addr, output logic [ApbDataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Read the mode register back and compare it with the shadow copy.
  task automatic check_mode_reg();
    logic [ApbDataW-1:0] rd;
    cfg_read(RegNat64Mode, rd);
    if (rd !== ApbDataW'(nat64_cfg)) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("register readback: expected %h, got %h", ApbDataW'(nat64_cfg), rd);
    end
  endtask

  task automatic set_nat64(input logic mode);
    wait_idle();
    cfg_write(RegNat64Mode, ApbDataW'(mode));
    nat64_cfg = mode;
    check_mode_reg();
  endtask

  task automatic test_reset_value();
    check_mode_reg();
  endtask

  // Field extremes, each message type with most of its mappings, and every drop reason.
  task automatic test_directed();
    send_hdr(mk_hdr(Icmp6EchoReq, 8'd0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    send_hdr(mk_hdr(Icmp6EchoReply, 8'hFF, 32'h0000_0000, 16'hFFFF, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6DestUnreach, Icmp6CodeNoRoute, 32'h1234_5678, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6DestUnreach, Icmp6CodeAdminProh, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6DestUnreach, Icmp6CodeAddrUnr, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6DestUnreach, Icmp6CodePortUnr, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6DestUnreach, 8'd5, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    // Packet too big: each candidate wins once, underflow clamps, no route drops.
    send_hdr(mk_hdr(Icmp6PktTooBig, 8'd0, 32'd1280, 16'h0, 16'd1500, 16'd1400, 1'b1));
    send_hdr(mk_hdr(Icmp6PktTooBig, 8'd0, 32'hFFFF_FFFF, 16'h0, 16'd5, 16'hFFFF, 1'b1));
    send_hdr(mk_hdr(Icmp6PktTooBig, 8'd0, 32'hFFFF_FFFF, 16'h0, 16'hFFFF, 16'd0, 1'b1));
    send_hdr(mk_hdr(Icmp6PktTooBig, 8'd0, 32'd10, 16'h0, 16'd1500, 16'd1500, 1'b0));
    send_hdr(mk_hdr(Icmp6TimeExceed, 8'hFF, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd2, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd6, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd7, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd23, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd24, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd39, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeErrHeader, 32'd40, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, Icmp6CodeNextHdr, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6ParamProb, 8'd2, 32'h0, 16'h0, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(8'd0, 8'd0, 32'h0, 16'h0, 16'h0, 16'h0, 1'b1));
    send_hdr(mk_hdr(8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // NAT64 mode replaces the echo identifier.
    set_nat64(1'b1);
    send_hdr(mk_hdr(Icmp6EchoReq, 8'd0, 32'h0000_FFFF, 16'hFFFF, 16'h0, 16'h0, 1'b0));
    send_hdr(mk_hdr(Icmp6EchoReply, 8'd0, 32'hFFFF_0000, 16'h0000, 16'h0, 16'h0, 1'b0));
  endtask

  // Random phases with changing mode and idling on both sides.
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      set_nat64((ph < 4) ? 1'(ph % 2) : 1'($urandom_range(0, 1)));
      tx_idle_pct = (ph == 1) ? 0 : 15;
      rx_idle_pct = (ph == 1) ? 0 : 15;
      repeat (240) send_hdr(rand_hdr());
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    repeat (60) send_hdr(rand_hdr());
  endtask

  // Final stretch at full rate on both sides.
  task automatic test_no_idle();
    set_nat64(~nat64_cfg);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (150) send_hdr(rand_hdr());
  endtask

  // Output side: random stall bursts, or one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int n = 0; n < HoldCycles; n++) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted output word with the oldest prediction.
  always @(posedge clk) begin : check_words
    icmp4_hdr_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_icmp4_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected word: type %0d code %0d rest %h verdict %0d",
                   icmp4_type, icmp4_code, icmp4_rest, verdict);
      end else begin
        want = pending_icmp4_q.pop_front();
        if (icmp4_type !== want.msg_type || icmp4_code !== want.code ||
            icmp4_rest !== want.rest || verdict !== want.verdict) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("word mismatch: expected type %0d code %0d rest %h verdict %0d, got type %0d code %0d rest %h verdict %0d",
                     want.msg_type, want.code, want.rest, want.verdict,
                     icmp4_type, icmp4_code, icmp4_rest, verdict);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    v6_type <= '0;
    v6_code <= '0;
    rest_word <= '0;
    mapped_echo_id <= '0;
    in_dev_mtu <= '0;
    out_dev_mtu <= '0;
    route_found <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_value();
    test_directed();
    test_random();
    test_backpressure();
    test_no_idle();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_icmp4_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
